FILE: src/morse_key_segment_encoder_macros.svh
// Assertion macros for the Morse key segment encoder.
`ifndef MORSE_KEY_SEGMENT_ENCODER_MACROS_SVH
`define MORSE_KEY_SEGMENT_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MKSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define MKSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define MKSE_ASSERT_SAME(label, ante, cons)
`define MKSE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/mkse_pkg.sv
// Package for the Morse key segment encoder: types, codes and the letter table.
`timescale 1ns / 1ps

package mkse_pkg;

    localparam int UNIT_W = 16;
    localparam int DUR_W = 19;
    localparam int CHAR_W = 8;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd150;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Segment length in units of one dot.
    typedef enum logic [1:0] {
        UNITS_1,
        UNITS_3,
        UNITS_7
    } t_units;

    // Element i of a pattern is bit i of code; a one is a dash.
    typedef struct packed {
        logic [2:0] len;
        logic [3:0] code;
    } t_pattern;

    function automatic t_pattern mkse_pattern(input logic [4:0] idx);
        t_pattern p;
        p = '0;
        unique case (idx)
            5'd0:  p = '{len: 3'd2, code: 4'b0010};
            5'd1:  p = '{len: 3'd4, code: 4'b0001};
            5'd2:  p = '{len: 3'd4, code: 4'b0101};
            5'd3:  p = '{len: 3'd3, code: 4'b0001};
            5'd4:  p = '{len: 3'd1, code: 4'b0000};
            5'd5:  p = '{len: 3'd4, code: 4'b0100};
            5'd6:  p = '{len: 3'd3, code: 4'b0011};
            5'd7:  p = '{len: 3'd4, code: 4'b0000};
            5'd8:  p = '{len: 3'd2, code: 4'b0000};
            5'd9:  p = '{len: 3'd4, code: 4'b1110};
            5'd10: p = '{len: 3'd3, code: 4'b0101};
            5'd11: p = '{len: 3'd4, code: 4'b0010};
            5'd12: p = '{len: 3'd2, code: 4'b0011};
            5'd13: p = '{len: 3'd2, code: 4'b0001};
            5'd14: p = '{len: 3'd3, code: 4'b0111};
            5'd15: p = '{len: 3'd4, code: 4'b0110};
            5'd16: p = '{len: 3'd4, code: 4'b1011};
            5'd17: p = '{len: 3'd3, code: 4'b0010};
            5'd18: p = '{len: 3'd3, code: 4'b0000};
            5'd19: p = '{len: 3'd1, code: 4'b0001};
            5'd20: p = '{len: 3'd3, code: 4'b0100};
            5'd21: p = '{len: 3'd4, code: 4'b1000};
            5'd22: p = '{len: 3'd3, code: 4'b0110};
            5'd23: p = '{len: 3'd4, code: 4'b1001};
            5'd24: p = '{len: 3'd4, code: 4'b1101};
            5'd25: p = '{len: 3'd4, code: 4'b0011};
            default: p = '{len: 3'd1, code: 4'b0000};
        endcase
        return p;
    endfunction

endpackage

FILE: src/morse_key_segment_encoder.sv
// Top level of the Morse key segment encoder: sequencer, duration unit and output register.
//
// Channel  Direction  Signals                                          Payload
// in       input      i_in_valid / o_in_ready                          i_character
// out      output     o_out_valid / i_out_ready                        o_key_closed,
//                                                                      o_duration_ticks,
//                                                                      o_last_segment
// cfg      input      i_cfg_valid / o_cfg_ready                        i_unit_length
//
// A letter of n elements yields 2n+1 segments, one per cycle while the output is taken;
// while a letter or a space is being sent the input is held, and any other byte is dropped
// on transfer.
// The segment counter steps the one shared multiply-by-1/3/7 add/subtract unit once per segment.
// Reset is synchronous and active low; unit_length returns to 150.
// A stalled output holds the sequencer; the next byte is taken while the final
// segment still waits in the output register.
`timescale 1ns / 1ps

module morse_key_segment_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mkse_pkg::CHAR_W-1:0]  i_character,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_key_closed,
    output logic [mkse_pkg::DUR_W-1:0]   o_duration_ticks,
    output logic                         o_last_segment,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mkse_pkg::UNIT_W-1:0]  i_unit_length
);
    import mkse_pkg::*;

`include "morse_key_segment_encoder_macros.svh"

    t_state                r_state, n_state;
    logic [UNIT_W-1:0]     r_unit;
    logic                  r_space, n_space;
    logic [2:0]            r_len, n_len;
    logic [3:0]            r_code, n_code;
    logic [3:0]            r_seg, n_seg;
    logic                  r_out_valid, n_out_valid;
    logic                  r_key, n_key;
    logic [DUR_W-1:0]      r_dur, n_dur;
    logic                  r_last, n_last;

    logic                  in_xfer;
    logic [CHAR_W-1:0]     upper;
    logic                  is_space;
    logic                  is_letter;
    t_pattern              pat;
    logic                  slot_free;
    logic                  seg_last;
    logic                  seg_key;
    t_units                seg_units;
    logic [DUR_W-1:0]      unit_ext;
    logic [DUR_W-1:0]      seg_dur;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // Fold lowercase to uppercase before classifying the byte.
    always_comb begin
        upper = i_character;
        if (i_character >= CHAR_LOWER_A && i_character <= CHAR_LOWER_Z) begin
            upper = i_character - CASE_OFFSET;
        end
        is_space = (upper == CHAR_SPACE);
        is_letter = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_Z);
        pat = mkse_pattern(5'(upper - CHAR_UPPER_A));
    end

    // Current segment: even slots are elements, odd slots element gaps, then the letter gap.
    always_comb begin
        seg_last = r_space || (r_seg == {r_len, 1'b0});
        seg_key = 1'b0;
        seg_units = UNITS_1;
        if (r_space) begin
            seg_units = UNITS_7;
        end else if (seg_last) begin
            seg_units = UNITS_3;
        end else if (!r_seg[0]) begin
            seg_key = 1'b1;
            seg_units = r_code[r_seg[2:1]] ? UNITS_3 : UNITS_1;
        end
    end

    // Shared duration unit: at most one add or subtract of shifted copies of the unit length.
    always_comb begin
        unit_ext = (r_unit == '0) ? DUR_W'(1) : DUR_W'(r_unit);
        unique case (seg_units)
            UNITS_1: seg_dur = unit_ext;
            UNITS_3: seg_dur = (unit_ext << 1) + unit_ext;
            UNITS_7: seg_dur = (unit_ext << 3) - unit_ext;
            default: seg_dur = unit_ext;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (is_space || is_letter)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (slot_free && seg_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_space = r_space;
        n_len = r_len;
        n_code = r_code;
        n_seg = r_seg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_key = r_key;
        n_dur = r_dur;
        n_last = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_space = is_space;
                    n_len = pat.len;
                    n_code = pat.code;
                    n_seg = '0;
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_key = seg_key;
                    n_dur = seg_dur;
                    n_last = seg_last;
                    n_seg = r_seg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_unit <= UNIT_RESET;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_unit <= i_unit_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_space <= n_space;
        r_len <= n_len;
        r_code <= n_code;
        r_seg <= n_seg;
        r_key <= n_key;
        r_dur <= n_dur;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_key_closed = r_key;
    assign o_duration_ticks = r_dur;
    assign o_last_segment = r_last;

    `MKSE_ASSERT_SAME(a_idle_holds_last, o_in_ready && o_out_valid, o_last_segment)
    `MKSE_ASSERT_SAME(a_tone_not_last, o_out_valid && o_key_closed, !o_last_segment)
    `MKSE_ASSERT_NEXT(a_more_follow, o_out_valid && !o_last_segment, o_out_valid)
    `MKSE_ASSERT_SAME(a_dur_nonzero, o_out_valid, o_duration_ticks != '0)

endmodule
